[sv/byte_level_pretoken_segmenter_macros.svh]
// ----------------------------------------------------------------------------
// Byte-level pre-token segmenter assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BYTE_LEVEL_PRETOKEN_SEGMENTER_MACROS_SVH
`define BYTE_LEVEL_PRETOKEN_SEGMENTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define BLPS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define BLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BLPS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define BLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/blps_pkg.sv]
// ----------------------------------------------------------------------------
// Pre-token segmenter package
// Run classes, byte constants and the item types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package blps_pkg;

    // Run classes; the low two bits are the reported run_class
    typedef enum logic [2:0] {
        RUN_SPACE = 3'd0,
        RUN_ALPHA = 3'd1,
        RUN_DIGIT = 3'd2,
        RUN_OTHER = 3'd3,
        RUN_NONE  = 3'd4
    } run_t;

    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [3:0] DIGIT_LIMIT_RESET = 4'd3;

    // Classification of one byte
    typedef struct packed {
        run_t       run;
        logic [1:0] tail_len;
    } class_info_t;

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [1:0] cls;
        logic       text_end;
    } result_t;

endpackage

`default_nettype wire

[sv/blps_classify.sv]
// ----------------------------------------------------------------------------
// Byte classifier
// Maps a raw byte to its run class and the tail length of a UTF-8 lead byte.
// ----------------------------------------------------------------------------
`default_nettype none

module blps_classify
    import blps_pkg::*;
(
    input  wire logic [7:0]  text_byte,
    output class_info_t      info
);

    // Pick the class of the byte
    always_comb
    begin
        info.tail_len = 2'd0;
        if (text_byte inside {SPACE_BYTE, [8'h09:8'h0D]})
        begin
            info.run = RUN_SPACE;
        end
        else if (text_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]})
        begin
            info.run = RUN_ALPHA;
        end
        else if (text_byte inside {[8'h30:8'h39]})
        begin
            info.run = RUN_DIGIT;
        end
        else
        begin
            info.run = RUN_OTHER;
            // Lead bytes take in one to three following bytes
            if (text_byte >= LEAD_FOUR)
            begin
                info.tail_len = 2'd3;
            end
            else if (text_byte >= LEAD_THREE)
            begin
                info.tail_len = 2'd2;
            end
            else if (text_byte >= LEAD_TWO)
            begin
                info.tail_len = 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/blps_core.sv]
// ----------------------------------------------------------------------------
// Segmenter core
// Holds run state and the group limit, and forms the result of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module blps_core
    import blps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  text_byte,
    input  wire logic        last_of_text,
    input  wire logic        cfg_write_en,
    input  wire logic [3:0]  cfg_write_data,
    output result_t          result
);

    class_info_t info;

    run_t       current_run_reg,          current_run_next;
    logic [3:0] digits_in_group_reg,      digits_in_group_next;
    logic [1:0] continuation_left_reg,    continuation_left_next;
    logic       single_space_pending_reg, single_space_pending_next;
    logic [3:0] digit_group_limit_reg;

    logic       start;
    run_t       cls;

    blps_classify u_classify
    (
        .text_byte (text_byte),
        .info      (info)
    );

    // Work out start flag and next state
    always_comb
    begin
        current_run_next          = current_run_reg;
        digits_in_group_next      = digits_in_group_reg;
        continuation_left_next    = continuation_left_reg;
        single_space_pending_next = single_space_pending_reg;
        cls                       = info.run;
        start                     = 1'b0;

        if (continuation_left_reg != 2'd0)
        begin
            // Tail byte of a multi-byte sequence
            cls                    = RUN_OTHER;
            continuation_left_next = continuation_left_reg - 2'd1;
        end
        else
        begin
            if (info.run == RUN_SPACE)
            begin
                start                     = (current_run_reg != RUN_SPACE);
                single_space_pending_next = start && (text_byte == SPACE_BYTE);
                digits_in_group_next      = 4'd0;
            end
            else
            begin
                if (info.run == RUN_DIGIT)
                begin
                    if (current_run_reg == RUN_DIGIT &&
                        digits_in_group_reg < digit_group_limit_reg)
                    begin
                        digits_in_group_next = digits_in_group_reg + 4'd1;
                    end
                    else
                    begin
                        start                = 1'b1;
                        digits_in_group_next = 4'd1;
                    end
                end
                else
                begin
                    start                = (current_run_reg != info.run);
                    digits_in_group_next = 4'd0;
                end
                // A lone space joins the token that follows
                if (single_space_pending_reg)
                begin
                    start = 1'b0;
                end
                single_space_pending_next = 1'b0;
                continuation_left_next    = info.tail_len;
            end
            current_run_next = info.run;
        end

        // Drop all run state after the final byte
        if (last_of_text)
        begin
            current_run_next          = RUN_NONE;
            digits_in_group_next      = 4'd0;
            continuation_left_next    = 2'd0;
            single_space_pending_next = 1'b0;
        end
    end

    assign result.data     = text_byte;
    assign result.start    = start;
    assign result.cls      = cls[1:0];
    assign result.text_end = last_of_text;

    // Advance state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_run_reg          <= RUN_NONE;
            digits_in_group_reg      <= 4'd0;
            continuation_left_reg    <= 2'd0;
            single_space_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            current_run_reg          <= current_run_next;
            digits_in_group_reg      <= digits_in_group_next;
            continuation_left_reg    <= continuation_left_next;
            single_space_pending_reg <= single_space_pending_next;
        end
    end

    // Hold the digit group limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_group_limit_reg <= DIGIT_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            digit_group_limit_reg <= cfg_write_data;
        end
    end

endmodule

`default_nettype wire

[sv/blps_out_skid.sv]
// ----------------------------------------------------------------------------
// Output skid buffer
// Two-entry result stage; input ready depends only on registered state.
// ----------------------------------------------------------------------------
`default_nettype none

module blps_out_skid
    import blps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire result_t push_item,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_item
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg,       main_next;
    result_t skid_reg,       skid_next;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    // Move items between main and skid entries
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next = push_item;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_item;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_item;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

[sv/byte_level_pretoken_segmenter.sv]
// An accepted byte is registered and reaches out_valid in the cycle after accept when the output is free.
// Throughput: one byte per cycle while in_ready is high; the run state is fed back from its own registers.
// A two-entry output stage keeps input ready while one result waits.
// Reset: rst_n clears run state and output valid; the limit returns to 3.
// ----------------------------------------------------------------------------
// Byte-level pre-token segmenter
// Marks pre-token starts in a byte stream, one byte per item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_level_pretoken_segmenter_macros.svh"

module byte_level_pretoken_segmenter
    import blps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        last_of_text,
    input  wire logic        cfg_write_en,
    input  wire logic [3:0]  cfg_write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             token_start,
    output logic [1:0]       run_class,
    output logic             text_end
);

    logic    in_accept;
    result_t core_res;
    result_t out_item;

    assign in_accept = in_valid && in_ready;

    blps_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .text_byte      (text_byte),
        .last_of_text   (last_of_text),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .result         (core_res)
    );

    blps_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (core_res),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign out_byte    = out_item.data;
    assign token_start = out_item.start;
    assign run_class   = out_item.cls;
    assign text_end    = out_item.text_end;

    // A full output stage always has a result on offer
    `BLPS_ASSERT_IMPLIES(a_stall_has_output, clk, rst_n, !in_ready, out_valid, "input stalled with no output")

    // An item entering an empty output shows up on the next cycle
    `BLPS_ASSERT_NEXT(a_empty_pass, clk, rst_n, in_accept && !out_valid, out_valid && (out_byte == $past(text_byte)), "item did not reach output")

    // A lead byte that opens a token is followed by a tail byte
    `BLPS_ASSERT_NEXT(a_lead_tail, clk, rst_n, in_accept && (text_byte >= LEAD_TWO) && core_res.start && !last_of_text, !in_accept || (!core_res.start && (core_res.cls == 2'(RUN_OTHER))), "tail byte not taken in")

endmodule

`default_nettype wire
